### sv/ipsc_pkg.sv
package ipsc_pkg;

    // field widths
    localparam int SPEED_W    = 12;
    localparam int STEER_W    = 13;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // duty ceiling
    localparam logic [DUTY_W-1:0] PWM_MAX = 16'd10000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LINE_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_GAIN     = 3'd4;

    // register reset values
    localparam logic [SPEED_W-1:0] LOST_LINE_SPEED_RST = 12'd0;
    localparam logic [SPEED_W-1:0] STRAIGHT_SPEED_RST  = 12'd4095;

    // floor(x/125) = (x * CORNER_RECIP) >> 24, exact for x < 2^17
    localparam logic [17:0] CORNER_RECIP = 18'd134218;
    // floor(x/5) = (x * PI_RECIP) >> 24, exact for x < 2^21
    localparam logic [21:0] PI_RECIP     = 22'd3355444;

    typedef struct packed {
        logic [SPEED_W-1:0] lost_line_speed;
        logic [SPEED_W-1:0] straight_speed;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  corner_gain;
    } cfg_t;

    // setpoint stage to pi stage
    typedef struct packed {
        logic                      valid;
        logic [SPEED_W-1:0]        setpoint;
        logic signed [STEER_W-1:0] spd_err;
        logic signed [STEER_W:0]   err_change;
    } sp_item_t;

endpackage

### sv/ipsc_in_if.sv
interface ipsc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [ipsc_pkg::SPEED_W-1:0]           target_speed;
    logic [ipsc_pkg::SPEED_W-1:0]           measured_speed;
    logic signed [ipsc_pkg::STEER_W-1:0]    steer_error;

    modport source (output valid, output target_speed, output measured_speed,
                    output steer_error, input ready);
    modport sink   (input valid, input target_speed, input measured_speed,
                    input steer_error, output ready);
endinterface

### sv/ipsc_out_if.sv
interface ipsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ipsc_pkg::DUTY_W-1:0]   pwm_duty;
    logic [ipsc_pkg::SPEED_W-1:0]  setpoint_used;

    modport source (output valid, output pwm_duty, output setpoint_used, input ready);
    modport sink   (input valid, input pwm_duty, input setpoint_used, output ready);
endinterface

### sv/incremental_pi_speed_control.sv
// channel    | dir | handshake     | payload
// speed_in   | in  | valid / ready | target_speed, measured_speed, steer_error
// duty_out   | out | valid / ready | pwm_duty, setpoint_used
// cfg        | in  | cfg_write_en  | cfg_index, cfg_data
//
// one item per cycle while no result is held; an item passes the input register,
// then six stages: corner product, corner divide, clamp and error, gain products,
// increment divide, duty accumulate
// reset clears all valids, the kept error and duty, and loads register defaults
// a stalled result holds the whole pipeline; speed_in.ready falls in that cycle
module incremental_pi_speed_control (
    input  logic                               clk,
    input  logic                               rst_n,
    ipsc_in_if.sink                            speed_in,
    ipsc_out_if.source                         duty_out,
    input  logic                               cfg_write_en,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ipsc_pkg::cfg_t                      cfg_reg;
    logic                                in_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        target_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        measured_reg;
    logic signed [ipsc_pkg::STEER_W-1:0] steer_reg;
    logic                                advance;
    logic                                out_valid;
    ipsc_pkg::sp_item_t                  sp_item;

    // whole pipeline moves unless the result is held
    assign advance        = !out_valid || duty_out.ready;
    assign speed_in.ready = advance;
    assign duty_out.valid = out_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_line_speed <= ipsc_pkg::LOST_LINE_SPEED_RST;
            cfg_reg.straight_speed  <= ipsc_pkg::STRAIGHT_SPEED_RST;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_p          <= '0;
            cfg_reg.corner_gain     <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ipsc_pkg::REG_LOST_LINE_SPEED:
                    cfg_reg.lost_line_speed <= cfg_data[ipsc_pkg::SPEED_W-1:0];
                ipsc_pkg::REG_STRAIGHT_SPEED:
                    cfg_reg.straight_speed  <= cfg_data[ipsc_pkg::SPEED_W-1:0];
                ipsc_pkg::REG_GAIN_I:
                    cfg_reg.gain_i          <= cfg_data;
                ipsc_pkg::REG_GAIN_P:
                    cfg_reg.gain_p          <= cfg_data;
                ipsc_pkg::REG_CORNER_GAIN:
                    cfg_reg.corner_gain     <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= speed_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && speed_in.valid)
        begin
            target_reg   <= speed_in.target_speed;
            measured_reg <= speed_in.measured_speed;
            steer_reg    <= speed_in.steer_error;
        end
    end

    // corner slowdown, clamp and speed error
    ipsc_setpoint u_setpoint (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .cfg            (cfg_reg),
        .in_valid       (in_valid_reg),
        .target_speed   (target_reg),
        .measured_speed (measured_reg),
        .steer_error    (steer_reg),
        .item           (sp_item)
    );

    // incremental pi law and duty accumulator
    ipsc_pi_update u_pi_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cfg           (cfg_reg),
        .item          (sp_item),
        .out_valid     (out_valid),
        .pwm_duty      (duty_out.pwm_duty),
        .setpoint_used (duty_out.setpoint_used)
    );

endmodule

### sv/ipsc_setpoint.sv
module ipsc_setpoint (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  ipsc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    input  logic [ipsc_pkg::SPEED_W-1:0]        target_speed,
    input  logic [ipsc_pkg::SPEED_W-1:0]        measured_speed,
    input  logic signed [ipsc_pkg::STEER_W-1:0] steer_error,
    output ipsc_pkg::sp_item_t                  item
);

    logic                                s1_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s1_target_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s1_measured_reg;
    logic [27:0]                         s1_slow_prod_reg;
    logic                                s2_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s2_target_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s2_measured_reg;
    logic [34:0]                         s2_slow_q_reg;
    logic                                s3_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s3_setpoint_reg;
    logic signed [ipsc_pkg::STEER_W-1:0] s3_error_reg;
    logic signed [ipsc_pkg::STEER_W:0]   s3_delta_reg;
    logic signed [ipsc_pkg::STEER_W-1:0] prev_error_reg;

    logic [ipsc_pkg::STEER_W-1:0]        steer_mag;
    logic [27:0]                         slow_prod_next;
    logic [34:0]                         slow_q_next;
    logic [10:0]                         slowdown;
    logic signed [ipsc_pkg::STEER_W-1:0] sp_raw;
    logic [ipsc_pkg::SPEED_W-1:0]        setpoint_next;
    logic signed [ipsc_pkg::STEER_W-1:0] error_next;
    logic signed [ipsc_pkg::STEER_W:0]   delta_next;

    // corner gain times steering magnitude (4096 fits unsigned)
    assign steer_mag      = steer_error[ipsc_pkg::STEER_W-1]
                          ? (~steer_error + 13'd1) : steer_error;
    assign slow_prod_next = cfg.corner_gain * steer_mag;

    // divide by 2048 then by 125 through the reciprocal
    assign slow_q_next = s1_slow_prod_reg[27:11] * ipsc_pkg::CORNER_RECIP;
    assign slowdown    = s2_slow_q_reg[34:24];

    // lowered setpoint, lower bound first then upper bound
    assign sp_raw = $signed({1'b0, s2_target_reg}) - $signed({2'b00, slowdown});

    always_comb
    begin
        setpoint_next = s2_target_reg;
        if (sp_raw < $signed({1'b0, cfg.lost_line_speed}))
        begin
            setpoint_next = cfg.lost_line_speed;
        end
        else
        begin
            setpoint_next = sp_raw[ipsc_pkg::SPEED_W-1:0];
        end
        if (setpoint_next > cfg.straight_speed)
        begin
            setpoint_next = cfg.straight_speed;
        end
    end

    // speed error and its change since the previous item
    assign error_next = $signed({1'b0, setpoint_next}) - $signed({1'b0, s2_measured_reg});
    assign delta_next = {error_next[ipsc_pkg::STEER_W-1], error_next}
                      - {prev_error_reg[ipsc_pkg::STEER_W-1], prev_error_reg};

    // stage valids and kept error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            prev_error_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                prev_error_reg <= error_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_target_reg    <= target_speed;
            s1_measured_reg  <= measured_speed;
            s1_slow_prod_reg <= slow_prod_next;
            s2_target_reg    <= s1_target_reg;
            s2_measured_reg  <= s1_measured_reg;
            s2_slow_q_reg    <= slow_q_next;
            s3_setpoint_reg  <= setpoint_next;
            s3_error_reg     <= error_next;
            s3_delta_reg     <= delta_next;
        end
    end

    assign item.valid      = s3_valid_reg;
    assign item.setpoint   = s3_setpoint_reg;
    assign item.spd_err    = s3_error_reg;
    assign item.err_change = s3_delta_reg;

endmodule

### sv/ipsc_pi_update.sv
module ipsc_pi_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  ipsc_pkg::cfg_t                cfg,
    input  ipsc_pkg::sp_item_t            item,
    output logic                          out_valid,
    output logic [ipsc_pkg::DUTY_W-1:0]   pwm_duty,
    output logic [ipsc_pkg::SPEED_W-1:0]  setpoint_used
);

    logic                                s4_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s4_setpoint_reg;
    logic signed [29:0]                  s4_prod_i_reg;
    logic signed [30:0]                  s4_prod_p_reg;
    logic                                s5_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s5_setpoint_reg;
    logic                                s5_neg_reg;
    logic [42:0]                         s5_q_reg;
    logic                                s6_valid_reg;
    logic [ipsc_pkg::SPEED_W-1:0]        s6_setpoint_reg;
    logic [ipsc_pkg::DUTY_W-1:0]         duty_reg;

    logic signed [29:0]                  prod_i_next;
    logic signed [30:0]                  prod_p_next;
    logic signed [31:0]                  num;
    logic [31:0]                         num_mag;
    logic [42:0]                         q_next;
    logic [18:0]                         inc_mag;
    logic signed [20:0]                  inc;
    logic signed [20:0]                  duty_sum;
    logic [ipsc_pkg::DUTY_W-1:0]         duty_next;

    // gain products
    assign prod_i_next = $signed({1'b0, cfg.gain_i}) * item.spd_err;
    assign prod_p_next = $signed({1'b0, cfg.gain_p}) * item.err_change;

    // sum, magnitude, divide by 512 then by 5 through the reciprocal
    assign num     = 32'(s4_prod_i_reg) + 32'(s4_prod_p_reg);
    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign q_next  = num_mag[29:9] * ipsc_pkg::PI_RECIP;

    // increment truncated toward zero, then saturating accumulate
    assign inc_mag  = s5_q_reg[42:24];
    assign inc      = s5_neg_reg ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    assign duty_sum = $signed({5'b00000, duty_reg}) + inc;

    always_comb
    begin
        priority if (duty_sum < 21'sd0)
        begin
            duty_next = '0;
        end
        else if (duty_sum > $signed({5'b00000, ipsc_pkg::PWM_MAX}))
        begin
            duty_next = ipsc_pkg::PWM_MAX;
        end
        else
        begin
            duty_next = duty_sum[ipsc_pkg::DUTY_W-1:0];
        end
    end

    // stage valids and kept duty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            duty_reg     <= '0;
        end
        else if (advance)
        begin
            s4_valid_reg <= item.valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            if (s5_valid_reg)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_setpoint_reg <= item.setpoint;
            s4_prod_i_reg   <= prod_i_next;
            s4_prod_p_reg   <= prod_p_next;
            s5_setpoint_reg <= s4_setpoint_reg;
            s5_neg_reg      <= num[31];
            s5_q_reg        <= q_next;
            s6_setpoint_reg <= s5_setpoint_reg;
        end
    end

    assign out_valid     = s6_valid_reg;
    assign pwm_duty      = duty_reg;
    assign setpoint_used = s6_setpoint_reg;

endmodule

### tb/incremental_pi_speed_control_tb.sv
module incremental_pi_speed_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipsc_pkg::*;

    localparam int LATENCY      = 7;
    localparam int DRAIN_PAUSE  = LATENCY + 4;
    localparam int MAX_GAP      = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 225;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_DIRECTED = 34;

    // corner slowdown and increment scaling of the control law
    localparam longint CORNER_DIV = 256000;
    localparam longint INC_DIV    = 2560;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0]  pwm_duty;
        logic [SPEED_W-1:0] setpoint;
    } duty_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      reg_index;
        logic [CFG_DATA_W-1:0]     reg_data;
        logic [SPEED_W-1:0]        target;
        logic [SPEED_W-1:0]        measured;
        logic signed [STEER_W-1:0] steer;
        logic                      has_want;
        duty_result_t              want;
    } stim_row_t;

    // directed sequence: register writes and items, typed results where obvious
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // reset defaults: zero gains, full window, no slowdown
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd0, 12'd0, 13'sd0, 1'b1, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd4095, 13'sd4095, 1'b1, '{16'd0, 12'd4095}},
        // most negative steering error
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, 13'h1000, 1'b1, '{16'd0, 12'd4095}},
        // full gains drive the duty to both rails
        '{ROW_WRITE, REG_GAIN_I, 16'd65535, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_GAIN_P, 16'd65535, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, 13'sd0, 1'b1, '{PWM_MAX, 12'd4095}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd0, 12'd4095, 13'sd0, 1'b1, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, 13'sd4095, 1'b1, '{PWM_MAX, 12'd4095}},
        // corner slowdown with a narrowed window, upper bits of a 12-bit write dropped
        '{ROW_WRITE, REG_GAIN_I, 16'd256, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_GAIN_P, 16'd512, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_CORNER_GAIN, 16'd65535, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_LOST_LINE_SPEED, 16'hF064, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_STRAIGHT_SPEED, 16'd4000, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd2000, 13'h1000, 1'b0, '{16'd0, 12'd0}},
        // slowdown larger than the target
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd500, 12'd100, 13'sd4095, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd4095, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd0, 12'd0, 13'sd1, 1'b0, '{16'd0, 12'd0}},
        // inverted window
        '{ROW_WRITE, REG_LOST_LINE_SPEED, 16'd3000, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_STRAIGHT_SPEED, 16'd1000, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd2000, 12'd1500, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, -13'sd1, 1'b0, '{16'd0, 12'd0}},
        // writes to unmapped indexes change nothing
        '{ROW_WRITE, REG_UNMAPPED_LO, 16'hFFFF, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_UNMAPPED_HI, 16'hFFFF, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd1234, 12'd1000, 13'sd2000, 1'b0, '{16'd0, 12'd0}},
        // window pinned at the top, proportional term only
        '{ROW_WRITE, REG_LOST_LINE_SPEED, 16'd4095, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_STRAIGHT_SPEED, 16'd4095, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_GAIN_I, 16'd0, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_GAIN_P, 16'd65535, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd0, 12'd4095, 13'h1000, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, 13'sd4095, 1'b0, '{16'd0, 12'd0}},
        // window pinned at the bottom
        '{ROW_WRITE, REG_LOST_LINE_SPEED, 16'd0, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_WRITE, REG_STRAIGHT_SPEED, 16'd0, 12'd0, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd4095, 12'd0, 13'sd0, 1'b0, '{16'd0, 12'd0}},
        '{ROW_ITEM,  REG_GAIN_I, 16'd0, 12'd0, 12'd4095, 13'sd0, 1'b0, '{16'd0, 12'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ipsc_in_if  speed_in ();
    ipsc_out_if duty_out ();

    incremental_pi_speed_control u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .speed_in     (speed_in),
        .duty_out     (duty_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the controller: registers, kept error and duty
    cfg_t                      shadow_cfg;
    logic signed [STEER_W-1:0] shadow_prev_error;
    logic [DUTY_W-1:0]         shadow_duty;

    duty_result_t pending_duty_q [$];

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  duty_at_floor   = 0;
    int  duty_at_ceiling = 0;
    int  idle_cycles     = 0;
    bit  src_burst       = 1'b0;
    bit  snk_burst       = 1'b0;
    bit  hold_request    = 1'b0;

    always #5 clk = ~clk;

    // one control tick of the incremental law, updating the shadow state
    function automatic duty_result_t compute_duty_tick(
        input logic [SPEED_W-1:0]        target,
        input logic [SPEED_W-1:0]        measured,
        input logic signed [STEER_W-1:0] steer
    );
        longint       steer_l = steer;
        longint       prev_l  = shadow_prev_error;
        longint       mag;
        longint       slow;
        longint       sp;
        longint       err;
        longint       num;
        longint       duty;
        duty_result_t r;
        mag  = (steer_l < 0) ? -steer_l : steer_l;
        slow = longint'(shadow_cfg.corner_gain) * mag / CORNER_DIV;
        sp   = longint'(target) - slow;
        // lower bound first, so an inverted window ends at the upper bound
        if (sp < longint'(shadow_cfg.lost_line_speed))
            sp = longint'(shadow_cfg.lost_line_speed);
        if (sp > longint'(shadow_cfg.straight_speed))
            sp = longint'(shadow_cfg.straight_speed);
        err  = sp - longint'(measured);
        num  = longint'(shadow_cfg.gain_i) * err + longint'(shadow_cfg.gain_p) * (err - prev_l);
        duty = longint'(shadow_duty) + num / INC_DIV;
        if (duty < 0)
            duty = 0;
        if (duty > longint'(PWM_MAX))
            duty = longint'(PWM_MAX);
        shadow_duty       = duty[DUTY_W-1:0];
        shadow_prev_error = err[STEER_W-1:0];
        r.pwm_duty = duty[DUTY_W-1:0];
        r.setpoint = sp[SPEED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // called at a falling edge with the channel idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        case (idx)
            REG_LOST_LINE_SPEED: shadow_cfg.lost_line_speed = data[SPEED_W-1:0];
            REG_STRAIGHT_SPEED:  shadow_cfg.straight_speed  = data[SPEED_W-1:0];
            REG_GAIN_I:          shadow_cfg.gain_i          = data;
            REG_GAIN_P:          shadow_cfg.gain_p          = data;
            REG_CORNER_GAIN:     shadow_cfg.corner_gain     = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // stop offering, let every result come back and the pipeline settle
    task automatic drain_pipeline();
        speed_in.valid = 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // offer one item; enters and leaves at a falling edge
    task automatic send_item(
        input logic [SPEED_W-1:0]        target,
        input logic [SPEED_W-1:0]        measured,
        input logic signed [STEER_W-1:0] steer,
        input logic                      has_want,
        input duty_result_t              want
    );
        int           gap;
        duty_result_t predicted;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            speed_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        speed_in.valid          = 1'b1;
        speed_in.target_speed   = target;
        speed_in.measured_speed = measured;
        speed_in.steer_error    = steer;
        do
            @(posedge clk);
        while (!speed_in.ready);
        predicted = compute_duty_tick(target, measured, steer);
        pending_duty_q.push_back(has_want ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // random tick, mostly a closed-loop looking one
    task automatic send_random_item();
        logic [SPEED_W-1:0]        target;
        logic [SPEED_W-1:0]        measured;
        logic signed [STEER_W-1:0] steer;
        int                        near;
        duty_result_t              none;
        none   = '0;
        target = SPEED_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) < 7)
        begin
            near = int'(target) + $urandom_range(0, 400) - 200;
            if (near < 0)
                near = 0;
            if (near > 4095)
                near = 4095;
            measured = near[SPEED_W-1:0];
        end
        else
            measured = SPEED_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 1) == 0)
            steer = STEER_W'($urandom_range(0, 8191));
        else
            steer = STEER_W'($signed($urandom_range(0, 600)) - 300);
        send_item(target, measured, steer, 1'b0, none);
    endtask

    // reset, directed rows, then random phases under different settings
    initial
    begin
        logic [CFG_DATA_W-1:0] lost;
        logic [CFG_DATA_W-1:0] straight;
        logic [CFG_DATA_W-1:0] gi;
        logic [CFG_DATA_W-1:0] gp;
        logic [CFG_DATA_W-1:0] corner;
        rst_n                   = 1'b0;
        cfg_write_en            = 1'b0;
        cfg_index               = REG_LOST_LINE_SPEED;
        cfg_data                = '0;
        speed_in.valid          = 1'b0;
        speed_in.target_speed   = '0;
        speed_in.measured_speed = '0;
        speed_in.steer_error    = '0;
        duty_out.ready          = 1'b0;
        shadow_cfg.lost_line_speed = LOST_LINE_SPEED_RST;
        shadow_cfg.straight_speed  = STRAIGHT_SPEED_RST;
        shadow_cfg.gain_i          = '0;
        shadow_cfg.gain_p          = '0;
        shadow_cfg.corner_gain     = '0;
        shadow_prev_error          = '0;
        shadow_duty                = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        settings_used = 1;
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                drain_pipeline();
                write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
                settings_used++;
            end
            else
                send_item(DIRECTED[i].target, DIRECTED[i].measured, DIRECTED[i].steer,
                          DIRECTED[i].has_want, DIRECTED[i].want);
        end

        // random phases
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipeline();
            case (phase)
                0:
                begin
                    lost = 16'd0; straight = 16'd4095;
                    gi = 16'hFFFF; gp = 16'hFFFF; corner = 16'hFFFF;
                end
                1, 2:
                begin
                    lost     = CFG_DATA_W'($urandom_range(0, 800));
                    straight = CFG_DATA_W'($urandom_range(2500, 4095));
                    gi       = CFG_DATA_W'($urandom_range(0, 1023));
                    gp       = CFG_DATA_W'($urandom_range(0, 2047));
                    corner   = CFG_DATA_W'($urandom_range(0, 20000));
                end
                3:
                begin
                    lost     = CFG_DATA_W'($urandom_range(2048, 4095));
                    straight = CFG_DATA_W'($urandom_range(0, 2047));
                    gi       = CFG_DATA_W'($urandom_range(0, 4095));
                    gp       = CFG_DATA_W'($urandom_range(0, 4095));
                    corner   = CFG_DATA_W'($urandom_range(0, 65535));
                end
                4:
                begin
                    lost     = CFG_DATA_W'($urandom_range(0, 65535));
                    straight = CFG_DATA_W'($urandom_range(0, 65535));
                    gi       = CFG_DATA_W'($urandom_range(0, 65535));
                    gp       = CFG_DATA_W'($urandom_range(0, 65535));
                    corner   = CFG_DATA_W'($urandom_range(0, 65535));
                end
                default:
                begin
                    lost = 16'd0; straight = 16'd0; gi = 16'd0; gp = 16'd0; corner = 16'd0;
                end
            endcase
            write_reg(REG_LOST_LINE_SPEED, lost);
            write_reg(REG_STRAIGHT_SPEED, straight);
            write_reg(REG_GAIN_I, gi);
            write_reg(REG_GAIN_P, gp);
            write_reg(REG_CORNER_GAIN, corner);
            settings_used++;
            src_burst = (phase == 2) || (phase == 4);
            snk_burst = (phase == 4) || (phase == 5);
            // back-pressure: receiver stops while the sender keeps offering
            if (phase == 2)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        drain_pipeline();
        repeat (DRAIN_PAUSE) @(posedge clk);
        $display("%0d items under %0d register settings, %0d results checked, %0d mismatches",
                 items_sent, settings_used, results_checked, mismatches);
        $display("duty reached the floor %0d times and the ceiling %0d times",
                 duty_at_floor, duty_at_ceiling);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        duty_result_t want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                duty_out.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                duty_out.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            duty_out.ready = 1'b1;
            do
                @(posedge clk);
            while (!duty_out.valid);
            if (pending_duty_q.size() == 0)
                report_mismatch("unexpected item, pwm_duty",
                                longint'(duty_out.pwm_duty), longint'(0));
            else
            begin
                want = pending_duty_q.pop_front();
                if (duty_out.pwm_duty !== want.pwm_duty)
                    report_mismatch("pwm_duty", longint'(duty_out.pwm_duty),
                                    longint'(want.pwm_duty));
                if (duty_out.setpoint_used !== want.setpoint)
                    report_mismatch("setpoint_used", longint'(duty_out.setpoint_used),
                                    longint'(want.setpoint));
                if (want.pwm_duty == '0)
                    duty_at_floor++;
                if (want.pwm_duty == PWM_MAX)
                    duty_at_ceiling++;
            end
            results_checked++;
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (speed_in.valid && speed_in.ready) || (duty_out.valid && duty_out.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles with no item moving", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

endmodule
